### rtl/core/whp_pkg.sv
// Shared types and constants for the WAV header chunk parser.
// Holds tag values, phase and status codes, and the structs passed between modules.
// No dependencies.
package whp_pkg;

    // Chunk and file tags as they appear gathered little-endian in a 32-bit word.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;

    localparam logic [6:0]  REQ_BITS_RESET     = 7'd16;
    localparam logic [15:0] MAX_CHANNELS_RESET = 16'd2;

    // Configuration register indexes.
    localparam logic CFG_REQUIRED_BITS = 1'b0;
    localparam logic CFG_MAX_CHANNELS  = 1'b1;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_HEAD,
        PH_FMT,
        PH_SKIP,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_OTHER,
        KIND_FMT,
        KIND_DATA
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BAD_RIFF,
        ST_BAD_WAVE,
        ST_NOT_PCM,
        ST_SHORT_FMT,
        ST_NO_FMT,
        ST_UNSUPPORTED,
        ST_TRUNCATED
    } status_t;

    typedef struct packed {
        logic [6:0]  required_bits;
        logic [15:0] max_channel_count;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] sample_rate;
        logic [15:0] channel_count;
        logic [15:0] sample_bits;
    } result_t;

endpackage

### rtl/core/whp_cfg.sv
// Configuration registers of the WAV header chunk parser.
// Depends on whp_pkg for the register indexes and the cfg_t struct.
module whp_cfg
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    logic [6:0]  req_bits_reg;
    logic [6:0]  req_bits_next;
    logic [15:0] max_chan_reg;
    logic [15:0] max_chan_next;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        req_bits_next = req_bits_reg;
        max_chan_next = max_chan_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_REQUIRED_BITS: req_bits_next = cfg_data[6:0];
                CFG_MAX_CHANNELS:  max_chan_next = cfg_data;
                default:           req_bits_next = req_bits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bits_reg <= REQ_BITS_RESET;
            max_chan_reg <= MAX_CHANNELS_RESET;
        end
        else
        begin
            req_bits_reg <= req_bits_next;
            max_chan_reg <= max_chan_next;
        end
    end

    assign cfg.required_bits     = req_bits_reg;
    assign cfg.max_channel_count = max_chan_reg;

endmodule

### rtl/core/whp_parse.sv
// Parser state and the per-byte update of the WAV header chunk parser.
// Depends on whp_pkg for tags, phase, kind and status codes and the structs.
module whp_parse
    import whp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       last_byte,
    input  cfg_t       cfg,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg,    phase_next,    phase_cur;
    logic [3:0]  index_reg,    index_next,    index_cur;
    logic [31:0] gather_reg,   gather_next,   gather_cur;
    kind_t       kind_reg,     kind_next,     kind_cur;
    logic [32:0] skip_reg,     skip_next,     skip_cur;
    logic        fmt_seen_reg, fmt_seen_next, fmt_seen_cur;
    logic [15:0] format_reg,   format_next,   format_cur;
    logic [31:0] rate_reg,     rate_next,     rate_cur;
    logic [15:0] chan_reg,     chan_next,     chan_cur;
    logic [15:0] bits_reg,     bits_next,     bits_cur;
    logic        verdict_reg,  verdict_next,  verdict_cur;

    logic        st_valid;
    status_t     st_code;
    status_t     data_status;
    logic [31:0] word;

    // A first byte clears the file state before the byte itself is taken.
    always_comb
    begin
        if (first_byte)
        begin
            phase_cur    = PH_RIFF;
            index_cur    = '0;
            gather_cur   = '0;
            kind_cur     = KIND_OTHER;
            skip_cur     = '0;
            fmt_seen_cur = 1'b0;
            format_cur   = '0;
            rate_cur     = '0;
            chan_cur     = '0;
            bits_cur     = '0;
            verdict_cur  = 1'b0;
        end
        else
        begin
            phase_cur    = phase_reg;
            index_cur    = index_reg;
            gather_cur   = gather_reg;
            kind_cur     = kind_reg;
            skip_cur     = skip_reg;
            fmt_seen_cur = fmt_seen_reg;
            format_cur   = format_reg;
            rate_cur     = rate_reg;
            chan_cur     = chan_reg;
            bits_cur     = bits_reg;
            verdict_cur  = verdict_reg;
        end
    end

    assign word = {data_byte, gather_cur[31:8]};

    always_comb
    begin
        if (!fmt_seen_cur)
            data_status = ST_NO_FMT;
        else if (rate_cur == '0 || chan_cur == '0 || bits_cur == '0)
            data_status = ST_UNSUPPORTED;
        else if (bits_cur != {9'd0, cfg.required_bits})
            data_status = ST_UNSUPPORTED;
        else if (chan_cur > cfg.max_channel_count)
            data_status = ST_UNSUPPORTED;
        else
            data_status = ST_OK;
    end

    always_comb
    begin
        phase_next    = phase_cur;
        index_next    = index_cur;
        gather_next   = gather_cur;
        kind_next     = kind_cur;
        skip_next     = skip_cur;
        fmt_seen_next = fmt_seen_cur;
        format_next   = format_cur;
        rate_next     = rate_cur;
        chan_next     = chan_cur;
        bits_next     = bits_cur;
        verdict_next  = verdict_cur;
        st_valid      = 1'b0;
        st_code       = ST_OK;

        if (!verdict_cur)
        begin
            gather_next = word;
            case (phase_cur)
                PH_RIFF, PH_RSIZE, PH_WAVE:
                begin
                    if (index_cur < 4'd3)
                        index_next = index_cur + 4'd1;
                    else
                    begin
                        index_next = '0;
                        if (phase_cur == PH_RIFF)
                        begin
                            if (word != TAG_RIFF)
                            begin
                                st_valid = 1'b1;
                                st_code  = ST_BAD_RIFF;
                            end
                            else
                                phase_next = PH_RSIZE;
                        end
                        else if (phase_cur == PH_RSIZE)
                            phase_next = PH_WAVE;
                        else if (word != TAG_WAVE)
                        begin
                            st_valid = 1'b1;
                            st_code  = ST_BAD_WAVE;
                        end
                        else
                            phase_next = PH_HEAD;
                    end
                end
                PH_HEAD:
                begin
                    if (index_cur == 4'd3)
                    begin
                        if (word == TAG_FMT)
                            kind_next = KIND_FMT;
                        else if (word == TAG_DATA)
                            kind_next = KIND_DATA;
                        else
                            kind_next = KIND_OTHER;
                    end
                    if (index_cur < 4'd7)
                        index_next = index_cur + 4'd1;
                    else
                    begin
                        // Size word complete: the body length plus a pad byte if odd.
                        index_next = '0;
                        if (kind_next == KIND_DATA)
                        begin
                            st_valid = 1'b1;
                            st_code  = data_status;
                        end
                        else if (kind_next == KIND_FMT)
                        begin
                            if (word < FMT_BODY_LEN)
                            begin
                                st_valid = 1'b1;
                                st_code  = ST_SHORT_FMT;
                            end
                            else
                            begin
                                skip_next  = {1'b0, word - FMT_BODY_LEN} + {32'd0, word[0]};
                                phase_next = PH_FMT;
                            end
                        end
                        else
                        begin
                            skip_next  = {1'b0, word} + {32'd0, word[0]};
                            phase_next = (skip_next != '0) ? PH_SKIP : PH_HEAD;
                        end
                    end
                end
                PH_FMT:
                begin
                    if (index_cur < 4'd2)
                    begin
                        if (index_cur[0])
                            format_next[15:8] = data_byte;
                        else
                            format_next[7:0] = data_byte;
                    end
                    else if (index_cur < 4'd4)
                    begin
                        if (index_cur[0])
                            chan_next[15:8] = data_byte;
                        else
                            chan_next[7:0] = data_byte;
                    end
                    else if (index_cur < 4'd8)
                    begin
                        case (index_cur[1:0])
                            2'd0:    rate_next[7:0]   = data_byte;
                            2'd1:    rate_next[15:8]  = data_byte;
                            2'd2:    rate_next[23:16] = data_byte;
                            default: rate_next[31:24] = data_byte;
                        endcase
                    end
                    else if (index_cur >= 4'd14)
                    begin
                        if (index_cur[0])
                            bits_next[15:8] = data_byte;
                        else
                            bits_next[7:0] = data_byte;
                    end

                    if (index_cur < 4'd15)
                        index_next = index_cur + 4'd1;
                    else if (format_next != FMT_PCM)
                    begin
                        st_valid = 1'b1;
                        st_code  = ST_NOT_PCM;
                    end
                    else
                    begin
                        fmt_seen_next = 1'b1;
                        index_next    = '0;
                        phase_next    = (skip_cur != '0) ? PH_SKIP : PH_HEAD;
                    end
                end
                PH_SKIP:
                begin
                    if (skip_cur != '0)
                        skip_next = skip_cur - 33'd1;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_HEAD;
                        index_next = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_cur;
                end
            endcase

            if (!st_valid && last_byte)
            begin
                st_valid = 1'b1;
                st_code  = ST_TRUNCATED;
            end
            if (st_valid)
            begin
                verdict_next = 1'b1;
                phase_next   = PH_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_RIFF;
            index_reg    <= '0;
            gather_reg   <= '0;
            kind_reg     <= KIND_OTHER;
            skip_reg     <= '0;
            fmt_seen_reg <= 1'b0;
            format_reg   <= '0;
            rate_reg     <= '0;
            chan_reg     <= '0;
            bits_reg     <= '0;
            verdict_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            index_reg    <= index_next;
            gather_reg   <= gather_next;
            kind_reg     <= kind_next;
            skip_reg     <= skip_next;
            fmt_seen_reg <= fmt_seen_next;
            format_reg   <= format_next;
            rate_reg     <= rate_next;
            chan_reg     <= chan_next;
            bits_reg     <= bits_next;
            verdict_reg  <= verdict_next;
        end
    end

    assign res_valid         = st_valid;
    assign res.status        = st_code;
    assign res.sample_rate   = rate_next;
    assign res.channel_count = chan_next;
    assign res.sample_bits   = bits_next;

endmodule

### rtl/core/wav_header_chunk_parser.sv
// Top level of the WAV header chunk parser: input register, parser, result register.
// Depends on whp_pkg, whp_cfg and whp_parse.
//
//  channel | signals                                     | direction
//  in      | in_valid, in_ready, data_byte, first/last   | byte stream in
//  out     | out_valid, out_ready, status, sample_rate,  | one verdict per file
//          | channel_count, sample_bits                  |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data   | register writes
//
// One byte is taken every cycle while no verdict waits unread; verdicts are registered.
// The rate is set by the combinational state update between input and result register.
// Reset clears the parser to expect a RIFF tag and loads the register defaults.
// While a verdict waits unread, one more byte item is held in the input register.
module wav_header_chunk_parser
    import whp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] sample_rate,
    output logic [15:0] channel_count,
    output logic [15:0] sample_bits,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    cfg_t        cfg;
    logic        in_full_reg;
    logic        in_full_next;
    logic [7:0]  byte_reg;
    logic        first_reg;
    logic        last_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     res;
    result_t     res_reg;
    logic        res_valid;
    logic        step;

    whp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The held item is processed once the result register has room for its verdict.
    assign step     = in_full_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_full_reg || step;

    whp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (byte_reg),
        .first_byte (first_reg),
        .last_byte  (last_reg),
        .cfg        (cfg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_comb
    begin
        if (in_valid && in_ready)
            in_full_next = 1'b1;
        else if (step)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;

        if (step && res_valid)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= data_byte;
            first_reg <= first_byte;
            last_reg  <= last_byte;
        end
        if (step && res_valid)
            res_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign sample_rate   = res_reg.sample_rate;
    assign channel_count = res_reg.channel_count;
    assign sample_bits   = res_reg.sample_bits;

`ifndef SYNTH
    // A held byte whose verdict has nowhere to go stays in the input register.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && out_valid_reg && !out_ready) |=> in_full_reg)
        else $error("input item lost while result register was blocked");

    // A verdict only appears from a processed byte.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step))
        else $error("result appeared without a processed item");

    // An accepted file must match the configured bit depth and channel limit.
    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status == ST_OK) |->
        (res_reg.sample_bits == {9'd0, cfg.required_bits} &&
         res_reg.channel_count <= cfg.max_channel_count &&
         res_reg.channel_count != '0 && res_reg.sample_rate != '0))
        else $error("ok verdict with fields outside the accepted range");
`endif

endmodule
